FILE: rtl/core/lockstep_time_barrier_defines.svh
// Assertion macros for the barrier RTL.
`ifndef LOCKSTEP_TIME_BARRIER_DEFINES_SVH
`define LOCKSTEP_TIME_BARRIER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define LTB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define LTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ltb_pkg.sv
package ltb_pkg;

	localparam int MAX_SLOTS_DEF = 32;
	localparam int KEY_BITS_DEF  = 32;

	localparam int KEY_FIELD_BITS = 32;
	localparam int EXP_BITS       = 6;
	localparam int TIME_BITS      = 64;
	localparam int S_TDATA_BITS   = 40;
	localparam int M_TDATA_BITS   = 72;
	localparam int CFG_IDX_BITS   = 2;

	localparam logic [1:0] KIND_READY = 2'd0;
	localparam logic [1:0] KIND_ACK   = 2'd1;

	localparam logic [1:0] REPLY_ACK = 2'd0;
	localparam logic [1:0] REPLY_ERR = 2'd1;
	localparam logic [1:0] REPLY_DUP = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_EXPECTED = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL = 2'd1;

	typedef struct packed {
		logic [1:0]           reply;
		logic                 bvalid;
		logic [TIME_BITS-1:0] btime;
	} res_t;

endpackage

FILE: rtl/core/ltb_key_ram.sv
module ltb_key_ram #(
	parameter int DEPTH = ltb_pkg::MAX_SLOTS_DEF,
	parameter int WIDTH = ltb_pkg::KEY_FIELD_BITS,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/ltb_seq.sv
module ltb_seq #(
	parameter int MAX_SLOTS = ltb_pkg::MAX_SLOTS_DEF,
	parameter int KEY_BITS  = ltb_pkg::KEY_BITS_DEF,
	localparam int CW = $clog2(MAX_SLOTS + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          in_kind,
	input  logic [ltb_pkg::KEY_FIELD_BITS-1:0]  in_key,
	input  logic [ltb_pkg::EXP_BITS-1:0]        expected,
	input  logic [ltb_pkg::TIME_BITS-1:0]       interval,
	output logic                                res_valid,
	input  logic                                res_take,
	output ltb_pkg::res_t                       res,
	output logic                                run_phase,
	output logic [CW-1:0]                       reg_count
);

	localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int KW = (KEY_BITS < ltb_pkg::KEY_FIELD_BITS) ? KEY_BITS
		: ltb_pkg::KEY_FIELD_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                      state_q;
	logic                            run_q;
	logic [CW-1:0]                   count_q;
	logic [ltb_pkg::TIME_BITS-1:0]   time_q;
	logic [MAX_SLOTS-1:0]            acked_q;
	logic [1:0]                      kind_q;
	logic [KW-1:0]                   key_q;
	logic [CW-1:0]                   idx_q;
	logic [CW-1:0]                   lim_q;
	logic                            found_q;
	logic                            all_q;
	ltb_pkg::res_t                   res_q;
	logic                            rd_vld_s1;
	logic [AW-1:0]                   rd_idx_s1;

	logic [CW-1:0]                   need;
	logic                            rd_en;
	logic [KW-1:0]                   rd_key;
	logic                            hit;
	logic                            mark;
	logic                            reg_full;
	logic [CW-1:0]                   count_nx;
	logic [ltb_pkg::TIME_BITS-1:0]   time_sum;
	logic                            wr_en;

	always_comb begin
		if (expected == '0) begin
			need = CW'(1);
		end else if (32'(expected) > 32'(MAX_SLOTS)) begin
			need = CW'(MAX_SLOTS);
		end else begin
			need = CW'(expected);
		end
	end

	assign rd_en    = (state_q == ST_SCAN) && (idx_q < lim_q);
	assign hit      = (CW'(rd_idx_s1) < count_q) && (rd_key == key_q);
	assign mark     = run_q && (kind_q == ltb_pkg::KIND_ACK) && hit && !found_q;
	assign reg_full = (count_q == CW'(MAX_SLOTS));
	assign count_nx = count_q + CW'(1);
	assign time_sum = time_q + interval;
	assign wr_en    = (state_q == ST_FIN) && !run_q && (kind_q == ltb_pkg::KIND_READY)
		&& !found_q && !reg_full;

	ltb_key_ram #(
		.DEPTH(MAX_SLOTS),
		.WIDTH(KW),
		.AW   (AW)
	) u_key_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[AW-1:0]),
		.wdata(key_q),
		.re   (rd_en),
		.raddr(idx_q[AW-1:0]),
		.rdata(rd_key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			run_q     <= 1'b0;
			count_q   <= '0;
			time_q    <= '0;
			acked_q   <= '0;
			kind_q    <= '0;
			key_q     <= '0;
			idx_q     <= '0;
			lim_q     <= '0;
			found_q   <= 1'b0;
			all_q     <= 1'b0;
			res_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			rd_idx_s1 <= idx_q[AW-1:0];
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						kind_q  <= in_kind;
						key_q   <= in_key[KW-1:0];
						found_q <= 1'b0;
						all_q   <= 1'b1;
						idx_q   <= '0;
						lim_q   <= run_q ? need : count_q;
						if (!run_q && (in_kind != ltb_pkg::KIND_READY)) begin
							res_q   <= '{reply: ltb_pkg::REPLY_ERR, bvalid: 1'b0, btime: '0};
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						idx_q <= idx_q + CW'(1);
					end
					if (rd_vld_s1) begin
						if (!run_q && hit) begin
							found_q <= 1'b1;
						end
						if (mark) begin
							found_q            <= 1'b1;
							acked_q[rd_idx_s1] <= 1'b1;
						end
						all_q <= all_q & (acked_q[rd_idx_s1] | mark);
					end
					// advance once the last read has come back
					if (!rd_en && !rd_vld_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_DONE;
					if (!run_q) begin
						if (found_q) begin
							res_q <= '{reply: ltb_pkg::REPLY_DUP, bvalid: 1'b0, btime: '0};
						end else if (reg_full) begin
							res_q <= '{reply: ltb_pkg::REPLY_ERR, bvalid: 1'b0, btime: '0};
						end else begin
							count_q <= count_nx;
							if (count_nx >= need) begin
								run_q   <= 1'b1;
								acked_q <= '0;
								res_q   <= '{reply: ltb_pkg::REPLY_ACK, bvalid: 1'b1,
									btime: time_q};
							end else begin
								res_q <= '{reply: ltb_pkg::REPLY_ACK, bvalid: 1'b0, btime: '0};
							end
						end
					end else if (all_q) begin
						time_q  <= time_sum;
						acked_q <= '0;
						res_q   <= '{reply: ltb_pkg::REPLY_ACK, bvalid: 1'b1, btime: time_sum};
					end else begin
						res_q <= '{reply: ltb_pkg::REPLY_ACK, bvalid: 1'b0, btime: '0};
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;
	assign run_phase = run_q;
	assign reg_count = count_q;

endmodule

FILE: rtl/core/lockstep_time_barrier.sv
// Channel   Dir  Payload (low bit first)                       Accepted when
// s_axis    in   kind[1:0], client_key[33:2]                   s_tvalid & s_tready
// m_axis    out  reply[1:0], bcast_valid[2], bcast_time[66:3]  m_tvalid & m_tready
// cfg       in   cfg_index selects register, cfg_wdata         cfg_we
//
// An item scans N slots: the registered clients while registering, the clamped expected
// count while running. The key memory is read one slot a cycle through a registered read
// port; a non-ready item while registering skips the scan and gets an error result.
// Reset clears phase, count, flags and time; the key memory is not cleared. One result
// waits in the output register while the next item is taken; a second result holds the
// sequencer until the first is taken.
`include "lockstep_time_barrier_defines.svh"

module lockstep_time_barrier #(
	parameter int MAX_SLOTS = ltb_pkg::MAX_SLOTS_DEF,
	parameter int KEY_BITS  = ltb_pkg::KEY_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ltb_pkg::S_TDATA_BITS-1:0]   s_tdata,   // kind, client_key
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ltb_pkg::M_TDATA_BITS-1:0]   m_tdata,   // reply, bcast_valid, bcast_time
	input  logic                               cfg_we,
	input  logic [ltb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [ltb_pkg::TIME_BITS-1:0]      cfg_wdata
);

	localparam int CW = $clog2(MAX_SLOTS + 1);

	logic [ltb_pkg::EXP_BITS-1:0]  expected_q;
	logic [ltb_pkg::TIME_BITS-1:0] interval_q;
	logic                          out_vld_q;
	ltb_pkg::res_t                 out_q;

	logic                          res_valid;
	logic                          res_take;
	ltb_pkg::res_t                 res;
	logic                          run_phase;
	logic [CW-1:0]                 reg_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= ltb_pkg::EXP_BITS'(1);
			interval_q <= ltb_pkg::TIME_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				ltb_pkg::CFG_EXPECTED: expected_q <= cfg_wdata[ltb_pkg::EXP_BITS-1:0];
				ltb_pkg::CFG_INTERVAL: interval_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	ltb_seq #(
		.MAX_SLOTS(MAX_SLOTS),
		.KEY_BITS (KEY_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (s_tdata[1:0]),
		.in_key   (s_tdata[ltb_pkg::KEY_FIELD_BITS+1:2]),
		.expected (expected_q),
		.interval (interval_q),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res),
		.run_phase(run_phase),
		.reg_count(reg_count)
	);

	assign res_take = res_valid && (!out_vld_q || m_tready);

	// hold the result until the far side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else begin
			if (res_take) begin
				out_vld_q <= 1'b1;
				out_q     <= res;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'b0, out_q.btime, out_q.bvalid, out_q.reply};

	`LTB_ASSERT_NOW(a_count_bound, 1'b1, 32'(reg_count) <= 32'(MAX_SLOTS),
		"registered count beyond slot count")
	`LTB_ASSERT_NEXT(a_run_sticky, run_phase, run_phase, "run phase left")
	`LTB_ASSERT_NOW(a_bcast_in_run, res_valid && res.bvalid, run_phase,
		"broadcast outside run phase")

endmodule
